// ===== src/rws_pkg.sv =====
`timescale 1ns / 1ps

package rws_pkg;

    // operation codes carried in tuser of the input stream
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // configuration register indexes
    localparam logic CFG_POP_SIZE = 1'b0;
    localparam logic CFG_INVERT   = 1'b1;

    // datapath widths, fixed by the 16-bit scores and the 7-bit population size
    localparam int SW = 16;          // score and fraction
    localparam int TW = SW + 7;      // running total
    localparam int LW = TW + 7;      // (i+1)*T
    localparam int PW = SW + TW;     // r*T
    localparam int GW = PW + 7;      // r*T*(n-1)

    typedef logic [2:0] t_step;

    localparam t_step S_IDLE = 3'd0;
    localparam t_step S_SUM  = 3'd1;
    localparam t_step S_MUL1 = 3'd2;
    localparam t_step S_MUL2 = 3'd3;
    localparam t_step S_WALK = 3'd4;
    localparam t_step S_OUT  = 3'd5;

    typedef enum logic [2:0] {
        C_NEVER   = 3'd0,
        C_DRAW    = 3'd1,
        C_LAST    = 3'd2,
        C_DEGEN   = 3'd3,
        C_HIT     = 3'd4,
        C_OUTFREE = 3'd5
    } t_cond;

    typedef struct packed {
        logic  take_in;
        logic  sum_en;
        logic  mul_r;
        logic  mul_n;
        logic  walk_en;
        logic  emit;
        logic  loop;
        t_cond jcond;
        t_step jaddr;
    } t_cw;

    typedef struct packed {
        logic draw;
        logic last;
        logic degen;
        logic hit;
        logic out_free;
    } t_flags;

    // microprogram: jump on condition, else hold the step (loop) or advance
    function automatic t_cw ucode(input t_step step);
        t_cw cw;
        cw = '0;
        case (step)
            S_IDLE: begin
                cw.take_in = 1'b1;
                cw.loop    = 1'b1;
                cw.jcond   = C_DRAW;
                cw.jaddr   = S_SUM;
            end
            S_SUM: begin
                cw.sum_en  = 1'b1;
                cw.loop    = 1'b1;
                cw.jcond   = C_LAST;
                cw.jaddr   = S_MUL1;
            end
            S_MUL1: begin
                cw.mul_r   = 1'b1;
                cw.jcond   = C_DEGEN;
                cw.jaddr   = S_OUT;
            end
            S_MUL2: begin
                cw.mul_n   = 1'b1;
                cw.jcond   = C_NEVER;
                cw.jaddr   = S_IDLE;
            end
            S_WALK: begin
                cw.walk_en = 1'b1;
                cw.loop    = 1'b1;
                cw.jcond   = C_HIT;
                cw.jaddr   = S_OUT;
            end
            S_OUT: begin
                cw.emit    = 1'b1;
                cw.loop    = 1'b1;
                cw.jcond   = C_OUTFREE;
                cw.jaddr   = S_IDLE;
            end
            default: begin
                cw.jcond   = C_NEVER;
                cw.jaddr   = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== src/roulette_wheel_selector.sv =====
`timescale 1ns / 1ps

// Roulette wheel (fitness-proportionate) selection over a table of scores.
// Input stream: tuser is the operation (0 load, 1 draw). A load beat writes
// fitness_score into entry entry_index and returns nothing. A draw beat carries
// random_fraction and returns one beat with the chosen index in tdata and the
// degenerate-total flag in tuser.
// Configuration: write population_size (index 0) and invert_mode (index 1)
// through the cfg channel, which is always ready.
// Timing: a draw over n entries sums the table, takes two multiply steps, walks
// the cumulative scores and ends in one output step; its length is set by the
// single read port of the score memory that both passes go through. A
// degenerate draw skips the second multiply step and the walk. No new beat is
// taken until a draw has placed its result.
// Output: a register holds the result; the next draw is taken while it waits,
// but its own result stalls in the output step until the receiver frees it.
// Reset clears the sequencer, the output valid and the registers
// (population_size 1, invert_mode 0); the score table is undefined until written.
module roulette_wheel_selector #(
    parameter int MAX_POPULATION = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // entry_index[5:0], fitness_score[21:6],
                                         // random_fraction[37:22], zero[39:38]
    input  logic        i_s_axis_tuser,  // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // selected_index[5:0], zero[7:6]
    output logic        o_m_axis_tuser,  // degenerate_total
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_POPULATION + 1);

    rws_pkg::t_cw    cw;
    rws_pkg::t_flags flags;

    logic          r_out_valid;
    logic [5:0]    r_out_sel;
    logic          r_out_degen;
    logic [6:0]    r_pop;
    logic          r_inv;

    logic          in_acc;
    logic          draw;
    logic          wr_en;
    logic [CW-1:0] pop_eff;
    logic          last;
    logic          degen_now;
    logic          hit;
    logic [5:0]    sel;
    logic          degen;
    logic          out_free;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = cw.take_in;
    assign in_acc          = i_s_axis_tvalid && cw.take_in;
    assign draw            = in_acc && (i_s_axis_tuser == rws_pkg::OP_DRAW);
    assign wr_en           = in_acc && (i_s_axis_tuser == rws_pkg::OP_LOAD)
                             && (32'(i_s_axis_tdata[5:0]) < MAX_POPULATION);

    always_comb begin
        if (r_pop == 7'd0) begin
            pop_eff = CW'(1);
        end else if (32'(r_pop) > MAX_POPULATION) begin
            pop_eff = CW'(MAX_POPULATION);
        end else begin
            pop_eff = CW'(r_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop <= 7'd1;
            r_inv <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rws_pkg::CFG_POP_SIZE: r_pop <= i_cfg_data;
                rws_pkg::CFG_INVERT:   r_inv <= i_cfg_data[0];
                default:               r_pop <= r_pop;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    assign flags.draw     = draw;
    assign flags.last     = last;
    assign flags.degen    = degen_now;
    assign flags.hit      = hit;
    assign flags.out_free = out_free;

    rws_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_cw    (cw)
    );

    rws_datapath #(
        .MAX_POPULATION (MAX_POPULATION)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cw        (cw),
        .i_draw      (draw),
        .i_wr_en     (wr_en),
        .i_wr_idx    (i_s_axis_tdata[5:0]),
        .i_wr_score  (i_s_axis_tdata[21:6]),
        .i_frac      (i_s_axis_tdata[37:22]),
        .i_pop_eff   (pop_eff),
        .i_invert    (r_inv),
        .o_last      (last),
        .o_degen_now (degen_now),
        .o_hit       (hit),
        .o_sel       (sel),
        .o_degen     (degen)
    );

    // load the output register in the output step once it is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cw.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw.emit && out_free) begin
            r_out_sel   <= sel;
            r_out_degen <= degen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_sel};
    assign o_m_axis_tuser  = r_out_degen;

endmodule

// ===== src/rws_sequencer.sv =====
`timescale 1ns / 1ps

module rws_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rws_pkg::t_flags i_flags,
    output rws_pkg::t_cw    o_cw
);

    rws_pkg::t_step r_step;
    rws_pkg::t_step n_step;
    rws_pkg::t_cw   cw;
    logic           jump;

    assign cw   = rws_pkg::ucode(r_step);
    assign o_cw = cw;

    always_comb begin
        case (cw.jcond)
            rws_pkg::C_NEVER:   jump = 1'b0;
            rws_pkg::C_DRAW:    jump = i_flags.draw;
            rws_pkg::C_LAST:    jump = i_flags.last;
            rws_pkg::C_DEGEN:   jump = i_flags.degen;
            rws_pkg::C_HIT:     jump = i_flags.hit;
            rws_pkg::C_OUTFREE: jump = i_flags.out_free;
            default:            jump = 1'b0;
        endcase
    end

    always_comb begin
        if (jump) begin
            n_step = cw.jaddr;
        end else if (cw.loop) begin
            n_step = r_step;
        end else begin
            n_step = r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rws_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== src/rws_datapath.sv =====
`timescale 1ns / 1ps

module rws_datapath #(
    parameter int MAX_POPULATION = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rws_pkg::t_cw                          i_cw,
    input  logic                                  i_draw,
    input  logic                                  i_wr_en,
    input  logic [5:0]                            i_wr_idx,
    input  logic [rws_pkg::SW-1:0]                i_wr_score,
    input  logic [rws_pkg::SW-1:0]                i_frac,
    input  logic [$clog2(MAX_POPULATION+1)-1:0]   i_pop_eff,
    input  logic                                  i_invert,
    output logic                                  o_last,
    output logic                                  o_degen_now,
    output logic                                  o_hit,
    output logic [5:0]                            o_sel,
    output logic                                  o_degen
);

    localparam int AW = $clog2(MAX_POPULATION);
    localparam int SW = rws_pkg::SW;
    localparam int TW = rws_pkg::TW;
    localparam int LW = rws_pkg::LW;
    localparam int PW = rws_pkg::PW;
    localparam int GW = rws_pkg::GW;

    logic [SW-1:0] r_mem [MAX_POPULATION];
    logic [SW-1:0] r_q;
    logic [AW-1:0] r_rp;
    logic [AW-1:0] r_i;
    logic [SW-1:0] r_frac;
    logic [TW-1:0] r_acc;
    logic [TW-1:0] r_cum;
    logic [LW-1:0] r_kt;
    logic [PW-1:0] r_prod;
    logic [GW-1:0] r_target;
    logic [5:0]    r_sel;
    logic          r_degen;

    logic [TW-1:0] n_cum;
    logic [LW-1:0] n_kt;
    logic [LW-1:0] lhs;
    logic [6:0]    mult_n;
    logic          cmp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[AW'(i_wr_idx)] <= i_wr_score;
        end
        r_q <= r_mem[r_rp];
    end

    assign o_last      = (32'(r_i) == 32'(i_pop_eff) - 32'd1);
    assign o_degen_now = (r_acc == '0) || (i_invert && (32'(i_pop_eff) == 32'd1));

    assign n_cum  = r_cum + TW'(r_q);
    assign n_kt   = r_kt + LW'(r_acc);
    assign lhs    = i_invert ? (n_kt - LW'(n_cum)) : LW'(n_cum);
    assign cmp    = ({lhs, 16'b0} >= r_target);
    assign o_hit  = cmp || o_last;
    assign mult_n = i_invert ? 7'(32'(i_pop_eff) - 32'd1) : 7'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0;
        end else if (i_draw || i_cw.mul_n) begin
            r_rp <= AW'(1);
        end else if (i_cw.mul_r || i_cw.emit) begin
            r_rp <= '0;
        end else if (i_cw.sum_en || i_cw.walk_en) begin
            r_rp <= r_rp + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_draw) begin
            r_frac <= i_frac;
            r_acc  <= '0;
            r_i    <= '0;
        end
        if (i_cw.sum_en) begin
            r_acc <= r_acc + TW'(r_q);
            r_i   <= r_i + AW'(1);
        end
        if (i_cw.mul_r) begin
            r_prod  <= PW'(r_frac) * PW'(r_acc);
            r_cum   <= '0;
            r_kt    <= '0;
            r_i     <= '0;
            r_sel   <= '0;
            r_degen <= o_degen_now;
        end
        if (i_cw.mul_n) begin
            r_target <= GW'(r_prod) * GW'(mult_n);
        end
        if (i_cw.walk_en) begin
            r_cum <= n_cum;
            r_kt  <= n_kt;
            r_i   <= r_i + AW'(1);
            if (o_hit) begin
                r_sel <= 6'(r_i);
            end
        end
    end

    assign o_sel   = r_sel;
    assign o_degen = r_degen;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int ITEM_TARGET   = 1550;
    localparam int CYCLE_LIMIT   = 1_500_000;

    // score patterns for a phase
    localparam int STYLE_WIDE   = 0;
    localparam int STYLE_SPARSE = 1;
    localparam int STYLE_ZERO   = 2;
    localparam int STYLE_TINY   = 3;
    localparam int STYLE_FULL   = 4;

    typedef struct packed {
        logic [5:0] pick;
        logic       degen;
    } t_pick;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;   // entry_index, fitness_score, random_fraction
    logic        i_s_axis_tuser  = 1'b0; // operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;         // selected_index
    logic        o_m_axis_tuser;         // degenerate_total
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index     = 1'b0;
    logic [6:0]  i_cfg_data      = '0;

    // view of the block's state, updated on accepted beats
    logic [15:0] score_tbl [TABLE_DEPTH];
    logic [6:0]  pop_shadow = 7'd1;
    logic        inv_shadow = 1'b0;
    t_pick       pick_q [$];

    bit          loaded [TABLE_DEPTH];
    int          src_idle_pct  = 26;
    int          sink_idle_pct = 26;
    int          rx_hold       = 0;
    int          err_cnt       = 0;
    int          beats_sent    = 0;
    int          draws_sent    = 0;
    int          results_seen  = 0;
    int          degen_seen    = 0;
    int          inv_draws     = 0;
    int          cycle_cnt     = 0;

    roulette_wheel_selector u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int active_n();
        if (pop_shadow == 7'd0) return 1;
        if (pop_shadow > TABLE_DEPTH) return TABLE_DEPTH;
        return int'(pop_shadow);
    endfunction

    // exact cross-multiplied walk over the cumulative scores
    function automatic t_pick predict_pick(input logic [15:0] frac);
        int        n, k;
        bit [63:0] total, cum, target, lhs;
        bit        found;
        t_pick     res;
        n     = active_n();
        total = 0;
        cum   = 0;
        found = 0;
        for (k = 0; k < n; k++) total += score_tbl[k];
        res.degen = (total == 0) || (inv_shadow && n == 1);
        res.pick  = '0;
        if (!res.degen) begin
            if (inv_shadow) target = 64'(frac) * total * 64'(n - 1);
            else target = 64'(frac) * total;
            res.pick = 6'(n - 1);
            for (k = 0; k < n && !found; k++) begin
                cum += score_tbl[k];
                if (inv_shadow) lhs = 64'(k + 1) * total - cum;
                else lhs = cum;
                if ((lhs << 16) >= target) begin
                    res.pick = 6'(k);
                    found    = 1;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : mon
        t_pick want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pick_q.size() == 0) begin
                    $error("result beat with nothing expected: index %0d flag %0b",
                           o_m_axis_tdata[5:0], o_m_axis_tuser);
                    err_cnt++;
                end else begin
                    want = pick_q.pop_front();
                    results_seen++;
                    if (want.degen) degen_seen++;
                    if (o_m_axis_tdata[5:0] !== want.pick) begin
                        $error("selected_index: expected %0d, actual %0d",
                               want.pick, o_m_axis_tdata[5:0]);
                        err_cnt++;
                    end
                    if (o_m_axis_tuser !== want.degen) begin
                        $error("degenerate_total: expected %0b, actual %0b",
                               want.degen, o_m_axis_tuser);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == rws_pkg::CFG_POP_SIZE) pop_shadow = i_cfg_data;
                else inv_shadow = i_cfg_data[0];
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (i_s_axis_tuser == rws_pkg::OP_LOAD) begin
                    score_tbl[i_s_axis_tdata[5:0]] = i_s_axis_tdata[21:6];
                end else begin
                    if (inv_shadow) inv_draws++;
                    pick_q.push_back(predict_pick(i_s_axis_tdata[37:22]));
                end
            end
        end
    end

    // output side: random stalls, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold--;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // called at a falling edge; leaves valid high so back-to-back beats stay high
    task automatic send_beat(input logic op, input logic [5:0] idx,
                             input logic [15:0] score, input logic [15:0] frac);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {2'b00, frac, score, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_load(input logic [5:0] idx, input logic [15:0] score);
        send_beat(rws_pkg::OP_LOAD, idx, score, 16'($urandom_range(65535)));
        loaded[idx] = 1'b1;
    endtask

    task automatic send_draw(input logic [15:0] frac);
        int k;
        // never let a draw read an entry that was never written
        for (k = 0; k < active_n(); k++)
            if (!loaded[k]) send_load(6'(k), 16'($urandom_range(65535)));
        send_beat(rws_pkg::OP_DRAW, 6'($urandom_range(63)), 16'($urandom_range(65535)),
                  frac);
        draws_sent++;
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pick_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [6:0] pop, input logic inv);
        settle();
        write_reg(rws_pkg::CFG_POP_SIZE, pop);
        write_reg(rws_pkg::CFG_INVERT, {6'd0, inv});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_score(input int style);
        case (style)
            STYLE_SPARSE: return ($urandom_range(99) < 85) ? 16'd0 : 16'($urandom_range(65535));
            STYLE_ZERO:   return ($urandom_range(99) < 95) ? 16'd0 : 16'($urandom_range(65535));
            STYLE_TINY:   return 16'($urandom_range(3));
            STYLE_FULL:   return 16'hFFFF - 16'($urandom_range(1));
            default:      return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_frac();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(255));
            3:       return 16'hFFFF - 16'($urandom_range(255));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic run_phase(input logic [6:0] pop, input logic inv,
                             input int style, input int count);
        int n, k;
        set_config(pop, inv);
        n = active_n();
        if (style == STYLE_ZERO)
            for (k = 0; k < n; k++) send_load(6'(k), 16'd0);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 70) send_draw(pick_frac());
            else if ($urandom_range(99) < 80)
                send_load(6'($urandom_range(n - 1)), pick_score(style));
            else send_load(6'($urandom_range(63)), pick_score(style));
        end
    endtask

    // registers still at their reset values
    task automatic test_reset_state();
        send_load(6'd0, 16'd0);
        send_draw(16'd0);
        send_load(6'd0, 16'hFFFF);
        send_draw(16'hFFFF);
    endtask

    task automatic test_proportional();
        set_config(7'd4, 1'b0);
        send_load(6'd0, 16'd0);
        send_load(6'd1, 16'hFFFF);
        send_load(6'd2, 16'd1);
        send_load(6'd3, 16'd0);
        send_draw(16'd0);
        send_draw(16'hFFFF);
        send_draw(16'h8000);
        send_draw(16'd1);
    endtask

    task automatic test_inverted();
        set_config(7'd4, 1'b1);
        send_draw(16'd0);
        send_draw(16'hFFFF);
        send_draw(16'h9C40);
        // single entry with inversion has no share to normalise
        set_config(7'd1, 1'b1);
        send_draw(16'h1234);
    endtask

    task automatic test_pop_bounds();
        set_config(7'd0, 1'b0);
        send_draw(16'h7FFF);
        set_config(7'd0, 1'b1);
        send_draw(16'h0100);
        // all-zero scores force index 0
        set_config(7'd2, 1'b0);
        send_load(6'd0, 16'd0);
        send_load(6'd1, 16'd0);
        send_draw(16'hAAAA);
    endtask

    task automatic test_full_table();
        int k;
        set_config(7'd64, 1'b0);
        for (k = 0; k < TABLE_DEPTH; k++) send_load(6'(k), pick_score(STYLE_WIDE));
        send_draw(16'd0);
        send_draw(16'hFFFF);
        send_load(6'd63, 16'hFFFF);
        send_draw(16'hFFFF);
        set_config(7'd127, 1'b1);
        send_draw(16'd0);
        send_draw(16'hFFFF);
        send_draw(pick_frac());
    endtask

    task automatic test_streaming();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(7'd16, 1'b0, STYLE_WIDE, 60);
        run_phase(7'd5, 1'b1, STYLE_SPARSE, 40);
        src_idle_pct  = 26;
        sink_idle_pct = 26;
    endtask

    // hold the output long enough for the block to fill and stall its input
    task automatic test_backpressure();
        int k;
        set_config(7'd8, 1'($urandom_range(1)));
        src_idle_pct = 0;
        rx_hold      = 600;
        for (k = 0; k < 8; k++) send_draw(pick_frac());
        src_idle_pct = 26;
    endtask

    task automatic test_random_mix();
        logic [6:0] pop;
        while (beats_sent < ITEM_TARGET) begin
            case ($urandom_range(9))
                0:       pop = 7'd0;
                1:       pop = 7'd1;
                2:       pop = 7'd64;
                3:       pop = 7'($urandom_range(65, 127));
                4, 5:    pop = 7'($urandom_range(2, 64));
                default: pop = 7'($urandom_range(2, 8));
            endcase
            run_phase(pop, 1'($urandom_range(1)), $urandom_range(STYLE_FULL),
                      $urandom_range(20, 50));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_proportional();
        test_inverted();
        test_pop_bounds();
        test_full_table();
        test_streaming();
        test_backpressure();
        test_random_mix();

        settle();
        $display("Sent %0d beats (%0d draws, %0d inverted); checked %0d results, %0d degenerate.",
                 beats_sent, draws_sent, inv_draws, results_seen, degen_seen);
        $display("Population sizes 0 to 127, both modes, streaming and a long output stall.");
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
